// ===== hdl/sgsp_pkg.sv =====
// Shared types, widths and codes for the ground segment snap probe.
// No dependencies; the core and the checker import it.
package sgsp_pkg;

   // table size default
   localparam int unsigned MaxSegmentsDefault = 256;

   // field and datapath widths (Q16.8 coordinates)
   localparam int unsigned CoordW  = 24;   // input/output coordinates
   localparam int unsigned CfgW    = 23;   // configuration registers
   localparam int unsigned CsrIdxW = 4;    // register index on the write port
   localparam int unsigned PxW     = 25;   // probe x
   localparam int unsigned SpanW   = 26;   // widened span bounds
   localparam int unsigned NumW    = 26;   // probe x minus start x
   localparam int unsigned DenW    = 25;   // |end x - start x|
   localparam int unsigned DyW     = 25;   // end y - start y
   localparam int unsigned ProdW   = 51;   // dy * num
   localparam int unsigned DivNW   = 52;   // dividend
   localparam int unsigned QuoW    = 26;   // quotient bits per division
   localparam int unsigned DivDW   = 26;   // divisor
   localparam int unsigned FracW   = 34;   // fraction test products
   localparam int unsigned HgtW    = 28;   // heights and window bounds
   localparam int unsigned SegW    = 4 * CoordW;  // one stored segment

   // operation codes
   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_PROBE = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // register indexes
   localparam logic [CsrIdxW-1:0] REG_HALF_WIDTH  = 4'd0;
   localparam logic [CsrIdxW-1:0] REG_HALF_HEIGHT = 4'd1;
   localparam logic [CsrIdxW-1:0] REG_MAX_DROP    = 4'd2;
   localparam logic [CsrIdxW-1:0] REG_MAX_RISE    = 4'd3;

   // register reset values
   localparam logic [CfgW-1:0] HALF_WIDTH_RST  = 23'd4096;
   localparam logic [CfgW-1:0] HALF_HEIGHT_RST = 23'd6144;
   localparam logic [CfgW-1:0] MAX_DROP_RST    = 23'd2048;
   localparam logic [CfgW-1:0] MAX_RISE_RST    = 23'd4608;

   // probe sequencer
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OFF_DIV,
      ST_READ,
      ST_LATCH,
      ST_TEST,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_WIN,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/sgsp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sgsp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ground_segment_snap_probe_core.sv =====
// Channel  | Ports                                   | Direction
// req      | req_valid/req_stall, operation, coords   | in
// rsp      | rsp_valid/rsp_stall, found, y, overflow   | out
// csr      | csr_valid/csr_ready, csr_index, csr_wdata | in, write only
//
// Load, clear and unused codes are answered straight from idle. A probe first
// computes the offset (a reciprocal multiply), then reads, unpacks and tests
// each segment; each probe x that passes the span and fraction tests adds a
// multiply, a dividend step, a run of the shared one-bit-per-cycle divider and
// the window check. A last state posts the result.
// The segment table sits in one RAM; only the fill count is reset, so no
// clearing pass is needed. A stalled result holds, and no new transaction is
// taken until the result slot frees.
//
// Ground segment snap probe top level; uses sgsp_pkg and sgsp_ram.
module ground_segment_snap_probe_core #(
   parameter int unsigned MAX_SEGMENTS = sgsp_pkg::MaxSegmentsDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_operation,
   input  logic signed [sgsp_pkg::CoordW-1:0] req_seg_start_x,
   input  logic signed [sgsp_pkg::CoordW-1:0] req_seg_start_y,
   input  logic signed [sgsp_pkg::CoordW-1:0] req_seg_end_x,
   input  logic signed [sgsp_pkg::CoordW-1:0] req_seg_end_y,
   input  logic signed [sgsp_pkg::CoordW-1:0] req_center_x,
   input  logic signed [sgsp_pkg::CoordW-1:0] req_center_y,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_found,
   output logic signed [sgsp_pkg::CoordW-1:0] rsp_snapped_center_y,
   output logic                             rsp_overflow,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sgsp_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [sgsp_pkg::CfgW-1:0]        csr_wdata
);
   import sgsp_pkg::*;

   localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
   // floor(x / 100) = (x * OffRecip) >> OffShift for any x below 2^30
   localparam logic [28:0] OffRecip = 29'd343597384;
   localparam int unsigned OffShift = 35;

   // configuration registers
   logic [CfgW-1:0] half_width_ff, half_height_ff, max_drop_ff, max_rise_ff;

   // control
   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    idx_ff;
   logic [1:0]       p_ff;
   logic             rsp_valid_ff, rsp_found_ff, rsp_overflow_ff;
   logic signed [CoordW-1:0] rsp_y_ff;

   // probe context
   logic signed [CoordW-1:0] cx_ff, cy_ff;
   logic [CfgW-1:0]          off_ff;
   logic [29:0]              off_num_ff;
   logic signed [HgtW-1:0]   bottom_ff, top_ff, best_ff;
   logic                     found_ff;

   // segment context
   logic signed [CoordW-1:0] x0_ff, y0_ff;
   logic signed [SpanW-1:0]  lo_ff, hi_ff;
   logic [DenW-1:0]          den_ff;
   logic                     seg_neg_ff;
   logic signed [DyW-1:0]    dy_ff;
   logic signed [ProdW-1:0]  prod_ff;
   logic signed [DivNW-1:0]  n_ff;

   // shared divider
   logic [DivDW-1:0] div_rem_ff;
   logic [QuoW-1:0]  div_quo_ff;
   logic [DivDW-1:0] div_d_ff;
   logic [4:0]       div_cnt_ff;
   logic             div_neg_ff;

   // handshakes
   logic req_acc, rsp_free, rsp_take, last_probe, last_seg, div_done, test_pass;
   logic [SegW-1:0] ram_rdata;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !rsp_free;
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign div_done  = (div_cnt_ff == 5'd0);
   assign last_probe = (p_ff == 2'd2);
   assign last_seg   = ((idx_ff + CW'(1)) == count_ff);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff  <= HALF_WIDTH_RST;
         half_height_ff <= HALF_HEIGHT_RST;
         max_drop_ff    <= MAX_DROP_RST;
         max_rise_ff    <= MAX_RISE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_HALF_WIDTH:  half_width_ff  <= csr_wdata;
            REG_HALF_HEIGHT: half_height_ff <= csr_wdata;
            REG_MAX_DROP:    max_drop_ff    <= csr_wdata;
            REG_MAX_RISE:    max_rise_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // segment table; writes happen only while idle, read data is used only while probing
   logic ram_we;
   assign ram_we = req_acc && (req_operation == OP_LOAD) &&
                   (count_ff != CW'(MAX_SEGMENTS));

   sgsp_ram #(.WIDTH(SegW), .DEPTH(MAX_SEGMENTS), .AW(AW)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data({req_seg_end_y, req_seg_end_x, req_seg_start_y, req_seg_start_x}),
      .rd_addr(idx_ff[AW-1:0]),
      .rd_data(ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:
            if (req_acc && (req_operation == OP_PROBE)) state_in = ST_OFF_DIV;
         ST_OFF_DIV:
            state_in = (count_ff == '0) ? ST_DONE : ST_READ;
         ST_READ:  state_in = ST_LATCH;
         ST_LATCH: state_in = ST_TEST;
         ST_TEST:
            if (test_pass) state_in = ST_MUL;
            else if (!last_probe) state_in = ST_TEST;
            else state_in = last_seg ? ST_DONE : ST_READ;
         ST_MUL:  state_in = ST_PREP;
         ST_PREP: state_in = ST_DIV;
         ST_DIV:  if (div_done) state_in = ST_WIN;
         ST_WIN:
            if (!last_probe) state_in = ST_TEST;
            else state_in = last_seg ? ST_DONE : ST_READ;
         ST_DONE: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // probe test datapath
   logic signed [PxW-1:0]   px;
   logic signed [NumW-1:0]  num_raw, num;
   logic signed [FracW-1:0] num100, den101, den_neg;

   always_comb begin
      case (p_ff)
         2'd1:    px = PxW'(cx_ff) - $signed({2'b0, off_ff});
         2'd2:    px = PxW'(cx_ff) + $signed({2'b0, off_ff});
         default: px = PxW'(cx_ff);
      endcase
      num_raw = NumW'(px) - NumW'(x0_ff);
      num     = seg_neg_ff ? -num_raw : num_raw;
      num100  = FracW'(num) * FracW'(100);
      den101  = $signed(FracW'(den_ff)) * FracW'(101);
      den_neg = -$signed(FracW'(den_ff));
      test_pass = (SpanW'(px) >= lo_ff) && (SpanW'(px) <= hi_ff) &&
                  (den_ff != '0) && (num100 >= den_neg) && (num100 <= den101);
   end

   // divider step: one quotient bit per cycle
   logic [DivDW:0]   div_r2;
   logic             div_ge;
   logic [DivDW:0]   div_sub;
   always_comb begin
      div_r2  = {div_rem_ff, div_quo_ff[QuoW-1]};
      div_ge  = (div_r2 >= {1'b0, div_d_ff});
      div_sub = div_r2 - {1'b0, div_d_ff};
   end

   // window check on the finished quotient
   logic signed [QuoW:0]   q_s;
   logic signed [HgtW-1:0] h;
   logic                   h_ok;
   always_comb begin
      q_s  = div_neg_ff ? -$signed({1'b0, div_quo_ff}) : $signed({1'b0, div_quo_ff});
      h    = HgtW'(y0_ff) + HgtW'(q_s);
      h_ok = (h >= bottom_ff) && (h <= top_ff);
   end

   // probe offset dividend, its scaled quotient and final result
   logic [29:0]              off_num;
   logic [58:0]              off_prod;
   logic signed [HgtW:0]     ny;
   logic signed [CoordW-1:0] ny_sat;
   always_comb begin
      off_num  = 30'(half_width_ff) * 30'd68 + 30'd50;
      off_prod = 59'(off_num_ff) * 59'(OffRecip);
      ny       = (HgtW+1)'(best_ff) + $signed({6'b0, half_height_ff});
      if (ny > (HgtW+1)'(8388607)) ny_sat = 24'sh7FFFFF;
      else if (ny < -(HgtW+1)'(8388608)) ny_sat = 24'sh800000;
      else ny_sat = ny[CoordW-1:0];
   end

   // dividend from the registered product; floor for negative numerators
   logic [DivDW-1:0] d2;
   logic [DivNW-1:0] m_val;
   always_comb begin
      d2    = {den_ff, 1'b0};
      m_val = n_ff[DivNW-1] ? (~n_ff + DivNW'(d2)) : n_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (req_acc && (req_operation == OP_LOAD) && ram_we) count_ff <= count_ff + CW'(1);
         if (req_acc && (req_operation == OP_CLEAR)) count_ff <= '0;
         // result slot: fill or drain
         if ((req_acc && (req_operation != OP_PROBE)) ||
             (state_ff == ST_DONE && rsp_free)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_PREP) begin
            div_cnt_ff <= 5'(QuoW);
         end else if (!div_done) begin
            div_cnt_ff <= div_cnt_ff - 5'd1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      // result payload
      if (req_acc && (req_operation != OP_PROBE)) begin
         rsp_found_ff    <= 1'b0;
         rsp_y_ff        <= '0;
         rsp_overflow_ff <= (req_operation == OP_LOAD) && !ram_we;
      end else if (state_ff == ST_DONE && rsp_free) begin
         rsp_found_ff    <= found_ff;
         rsp_y_ff        <= found_ff ? ny_sat : cy_ff;
         rsp_overflow_ff <= 1'b0;
      end

      // divider
      if (state_ff == ST_PREP) begin
         div_rem_ff <= m_val[DivNW-1:QuoW];
         div_quo_ff <= m_val[QuoW-1:0];
         div_d_ff   <= d2;
         div_neg_ff <= n_ff[DivNW-1];
      end else if (!div_done) begin
         div_rem_ff <= div_ge ? div_sub[DivDW-1:0] : div_r2[DivDW-1:0];
         div_quo_ff <= {div_quo_ff[QuoW-2:0], div_ge};
      end

      unique case (state_ff)
         ST_IDLE: begin
            // capture the probe and its height window
            cx_ff      <= req_center_x;
            cy_ff      <= req_center_y;
            off_num_ff <= off_num;
            bottom_ff  <= HgtW'(req_center_y) - $signed(HgtW'(half_height_ff))
                          - $signed(HgtW'(max_drop_ff));
            top_ff     <= HgtW'(req_center_y) - $signed(HgtW'(half_height_ff))
                          + $signed(HgtW'(max_rise_ff));
            found_ff   <= 1'b0;
            best_ff    <= '0;
            idx_ff     <= '0;
         end
         ST_OFF_DIV: off_ff <= off_prod[OffShift +: CfgW];
         ST_LATCH: begin
            // unpack the segment and normalize direction
            logic signed [CoordW-1:0] x0, y0, x1, y1;
            logic signed [DenW-1:0]   dx;
            x0 = ram_rdata[CoordW-1:0];
            y0 = ram_rdata[2*CoordW-1:CoordW];
            x1 = ram_rdata[3*CoordW-1:2*CoordW];
            y1 = ram_rdata[4*CoordW-1:3*CoordW];
            dx = DenW'(x1) - DenW'(x0);
            x0_ff      <= x0;
            y0_ff      <= y0;
            seg_neg_ff <= dx[DenW-1];
            den_ff     <= dx[DenW-1] ? DenW'(-dx) : DenW'(dx);
            dy_ff      <= DyW'(y1) - DyW'(y0);
            lo_ff      <= ((x0 < x1) ? SpanW'(x0) : SpanW'(x1)) - SpanW'(128);
            hi_ff      <= ((x0 < x1) ? SpanW'(x1) : SpanW'(x0)) + SpanW'(128);
            p_ff       <= 2'd0;
         end
         ST_TEST: begin
            prod_ff <= ProdW'(dy_ff) * ProdW'(num);
            if (!test_pass) begin
               p_ff <= p_ff + 2'd1;
               if (last_probe) idx_ff <= idx_ff + CW'(1);
            end
         end
         ST_MUL: n_ff <= (DivNW'(prod_ff) <<< 1) + $signed(DivNW'(den_ff));
         ST_WIN: begin
            // keep the highest height inside the window
            if (h_ok && (!found_ff || h > best_ff)) begin
               found_ff <= 1'b1;
               best_ff  <= h;
            end
            p_ff <= p_ff + 2'd1;
            if (last_probe) idx_ff <= idx_ff + CW'(1);
         end
         default: ;
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_snapped_center_y = rsp_y_ff;
   assign rsp_overflow         = rsp_overflow_ff;

endmodule

// ===== hdl/sgsp_checker.sv =====
// Port-level checks for the ground segment snap probe and their bind.
// Uses sgsp_pkg; attaches to ground_segment_snap_probe_core.
module sgsp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [1:0]                         req_operation,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_found,
   input logic                               rsp_overflow
);
   import sgsp_pkg::*;

   // a stalled result transaction stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // load, clear and unused codes answer in the next cycle
   a_fast_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_operation != OP_PROBE) |=> rsp_valid)
      else $error("missing immediate result");

   // a probe keeps the input side busy while it walks the table
   a_probe_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_operation == OP_PROBE) |=> req_stall)
      else $error("input taken during a probe");

   // a dropped load never reports a surface
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> !rsp_found)
      else $error("overflow and found both set");

endmodule

bind ground_segment_snap_probe_core sgsp_checker u_sgsp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_operation(req_operation),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_found    (rsp_found),
   .rsp_overflow (rsp_overflow)
);
